// ===== design/iprt_pkg.sv =====
// Shared constants, codes and controller/datapath link types for the prefix rule trie.
`default_nettype none

package iprt_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned PLEN_W = 6;
    localparam int unsigned STS_W  = 2;

    localparam logic [PLEN_W-1:0] MAX_DEPTH = PLEN_W'(32);

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STS_W-1:0] STS_DONE   = 2'd0;
    localparam logic [STS_W-1:0] STS_SHADOW = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL   = 2'd2;

    typedef struct packed {
        logic init;
        logic start;
        logic step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/iprt_in_if.sv =====
// Request channel: rule additions and address queries.
`default_nettype none

interface iprt_in_if import iprt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ADDR_W-1:0] address;
    logic [PLEN_W-1:0] prefix_length;
    logic              permit;

    modport source (output valid, output opcode, output address, output prefix_length,
                    output permit, input ready);
    modport sink   (input valid, input opcode, input address, input prefix_length,
                    input permit, output ready);
endinterface

`default_nettype wire

// ===== design/iprt_out_if.sv =====
// Response channel: verdict and status of each request.
`default_nettype none

interface iprt_out_if import iprt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             allowed;
    logic [STS_W-1:0] status;

    modport source (output valid, output allowed, output status, input ready);
    modport sink   (input valid, input allowed, input status, output ready);
endinterface

`default_nettype wire

// ===== design/iprt_dp.sv =====
// Datapath of the prefix rule trie: node memory, walk registers and result registers.
`default_nettype none

module iprt_dp import iprt_pkg::*; #(
    parameter int unsigned NODE_COUNT = 65536
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire t_cmd         i_cmd,
    input  wire               i_opcode,
    input  wire  [ADDR_W-1:0] i_address,
    input  wire  [PLEN_W-1:0] i_prefix_length,
    input  wire               i_permit,
    output t_sts              o_sts,
    output logic              o_allowed,
    output logic [STS_W-1:0]  o_status
);

    localparam int unsigned AW = $clog2(NODE_COUNT);
    localparam int unsigned FW = $clog2(NODE_COUNT + 1);

    typedef struct packed {
        logic          valid;
        logic          permit;
        logic [AW-1:0] child1;
        logic [AW-1:0] child0;
    } t_node;

    t_node r_mem [NODE_COUNT];
    t_node r_q;

    logic              r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [PLEN_W-1:0] r_plen;
    logic              r_permit;
    logic [PLEN_W-1:0] r_level;
    logic [AW-1:0]     r_pos;
    logic              r_fresh;
    logic              r_verdict;
    logic [FW-1:0]     r_next_free;
    logic              r_res_allowed;
    logic [STS_W-1:0]  r_res_status;
    logic              r_out_allowed;
    logic [STS_W-1:0]  r_out_status;

    t_node             w_cur;
    logic              w_bit;
    logic [AW-1:0]     w_nxt;
    logic              w_full;
    logic              w_verdict;
    logic              w_done;
    logic              w_we;
    logic [AW-1:0]     w_wa;
    t_node             w_wd;
    logic [AW-1:0]     w_rd_addr;
    logic              w_descend;
    logic              w_alloc;
    logic [AW-1:0]     n_pos;
    logic              w_allowed;
    logic [STS_W-1:0]  w_status;

    // A node allocated in this walk has not been written yet; it reads as empty.
    assign w_cur     = r_fresh ? t_node'('0) : r_q;
    assign w_bit     = r_addr[ADDR_W-1];
    assign w_nxt     = w_bit ? w_cur.child1 : w_cur.child0;
    assign w_full    = (r_next_free >= FW'(NODE_COUNT));
    assign w_verdict = w_cur.valid ? w_cur.permit : r_verdict;

    always_comb begin
        w_done    = 1'b0;
        w_we      = 1'b0;
        w_wa      = r_pos;
        w_wd      = w_cur;
        w_rd_addr = '0;
        w_descend = 1'b0;
        w_alloc   = 1'b0;
        n_pos     = w_nxt;
        w_allowed = 1'b0;
        w_status  = STS_DONE;
        if (i_cmd.init) begin
            w_we = 1'b1;
            w_wa = '0;
            w_wd = '0;
        end else if (i_cmd.step) begin
            if (r_op == OP_ADD) begin
                if (w_cur.valid) begin
                    w_done   = 1'b1;
                    w_status = STS_SHADOW;
                end else if (r_level == r_plen) begin
                    w_done        = 1'b1;
                    w_we          = 1'b1;
                    w_wd.valid    = 1'b1;
                    w_wd.permit   = r_permit;
                end else if (w_nxt == '0) begin
                    if (w_full) begin
                        // The fresh node stays allocated, so it is written out empty.
                        w_done   = 1'b1;
                        w_status = STS_FULL;
                        w_we     = r_fresh;
                    end else begin
                        w_alloc   = 1'b1;
                        w_descend = 1'b1;
                        w_we      = 1'b1;
                        n_pos     = r_next_free[AW-1:0];
                        if (w_bit) begin
                            w_wd.child1 = r_next_free[AW-1:0];
                        end else begin
                            w_wd.child0 = r_next_free[AW-1:0];
                        end
                    end
                end else begin
                    w_descend = 1'b1;
                    w_rd_addr = w_nxt;
                end
            end else begin
                if (r_level == MAX_DEPTH || w_nxt == '0) begin
                    w_done    = 1'b1;
                    w_allowed = w_verdict;
                end else begin
                    w_descend = 1'b1;
                    w_rd_addr = w_nxt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_q <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= FW'(1);
        end else if (w_alloc) begin
            r_next_free <= r_next_free + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op      <= i_opcode;
            r_addr    <= i_address;
            r_plen    <= (i_prefix_length > MAX_DEPTH) ? MAX_DEPTH : i_prefix_length;
            r_permit  <= i_permit;
            r_level   <= '0;
            r_pos     <= '0;
            r_fresh   <= 1'b0;
            r_verdict <= 1'b1;
        end else if (w_descend) begin
            r_addr    <= {r_addr[ADDR_W-2:0], 1'b0};
            r_level   <= r_level + PLEN_W'(1);
            r_pos     <= n_pos;
            r_fresh   <= w_alloc;
            r_verdict <= w_verdict;
        end
        if (w_done) begin
            r_res_allowed <= w_allowed;
            r_res_status  <= w_status;
        end
        if (i_cmd.load_out) begin
            r_out_allowed <= r_res_allowed;
            r_out_status  <= r_res_status;
        end
    end

    assign o_sts.done = w_done;
    assign o_allowed  = r_out_allowed;
    assign o_status   = r_out_status;

endmodule

`default_nettype wire

// ===== design/iprt_ctrl.sv =====
// Controller of the prefix rule trie: sequences root set-up, the trie walk and the handshakes.
`default_nettype none

module iprt_ctrl import iprt_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire       i_out_ready,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_cmd.init     = (r_state == ST_INIT);
    assign o_cmd.start    = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.step     = (r_state == ST_WALK);
    assign o_cmd.load_out = (r_state == ST_HOLD) && w_out_free;
    assign o_out_valid    = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_HOLD) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_INIT: begin
                    r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (i_sts.done) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_INIT;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/ipv4_prefix_rule_trie.sv =====
// Walk: an add descends at most to its prefix length and a query at most to depth 32, one walk
// step per trie level, set by the node memory's registered read.
// Transactions: one at a time; a response may wait at the output while the next is accepted.
// Reset: synchronous, active low; after reset the init state writes the empty root node,
// and requests are accepted once the idle state is reached. Other nodes are written on allocation.
`default_nettype none

module ipv4_prefix_rule_trie import iprt_pkg::*; #(
    parameter int unsigned NODE_COUNT = 65536
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    iprt_in_if.sink    i_req,
    iprt_out_if.source o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;

    iprt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    iprt_dp #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_opcode        (i_req.opcode),
        .i_address       (i_req.address),
        .i_prefix_length (i_req.prefix_length),
        .i_permit        (i_req.permit),
        .o_sts           (w_sts),
        .o_allowed       (o_rsp.allowed),
        .o_status        (o_rsp.status)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the IPv4 prefix rule trie: rule adds and address queries.
`timescale 1ns / 100ps

module tb;
    import iprt_pkg::*;

    // A small node table so that the table really does fill up within the run.
    localparam int unsigned TRIE_NODES   = 4096;
    localparam int          RANDOM_ITEMS = 1500;
    // Up to about 2500 transactions, plus stalls, with ample margin.
    localparam int          CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [PLEN_W-1:0] plen;
        logic              permit;
        logic              fixed;
        logic              allowed;
        logic [STS_W-1:0]  status;
    } t_request;

    typedef struct packed {
        logic             allowed;
        logic [STS_W-1:0] status;
    } t_verdict;

    // Fields: opcode, address, prefix length, permit, expectation typed in, allowed, status.
    localparam t_request OPENING [24] = '{
        '{OP_QUERY, 32'h0000_0000, 6'd0,  1'b0, 1'b1, 1'b1, STS_DONE},
        '{OP_QUERY, 32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, 1'b1, STS_DONE},
        '{OP_ADD,   32'h0A00_0000, 6'd8,  1'b0, 1'b1, 1'b0, STS_DONE},
        '{OP_ADD,   32'h0A00_0000, 6'd8,  1'b1, 1'b1, 1'b0, STS_SHADOW},
        '{OP_ADD,   32'h0A01_0000, 6'd16, 1'b1, 1'b1, 1'b0, STS_SHADOW},
        '{OP_QUERY, 32'h0AC8_0304, 6'd21, 1'b1, 1'b1, 1'b0, STS_DONE},
        '{OP_QUERY, 32'h0B00_0000, 6'd0,  1'b0, 1'b1, 1'b1, STS_DONE},
        '{OP_ADD,   32'hFFFF_FFFF, 6'd32, 1'b0, 1'b1, 1'b0, STS_DONE},
        '{OP_QUERY, 32'hFFFF_FFFF, 6'd0,  1'b0, 1'b1, 1'b0, STS_DONE},
        '{OP_QUERY, 32'hFFFF_FFFE, 6'd0,  1'b0, 1'b1, 1'b1, STS_DONE},
        '{OP_ADD,   32'hFFFF_FFFF, 6'd63, 1'b1, 1'b1, 1'b0, STS_SHADOW},
        '{OP_ADD,   32'h1234_5678, 6'd40, 1'b1, 1'b1, 1'b0, STS_DONE},
        '{OP_ADD,   32'h1234_5678, 6'd32, 1'b0, 1'b1, 1'b0, STS_SHADOW},
        '{OP_QUERY, 32'h1234_5679, 6'd0,  1'b0, 1'b0, 1'b0, STS_DONE},
        '{OP_ADD,   32'h1234_5679, 6'd33, 1'b0, 1'b0, 1'b0, STS_DONE},
        '{OP_QUERY, 32'h1234_5679, 6'd0,  1'b0, 1'b0, 1'b0, STS_DONE},
        '{OP_ADD,   32'hC0A9_0100, 6'd24, 1'b0, 1'b0, 1'b0, STS_DONE},
        '{OP_ADD,   32'hC0A9_0000, 6'd16, 1'b1, 1'b0, 1'b0, STS_DONE},
        '{OP_QUERY, 32'hC0A9_0105, 6'd0,  1'b0, 1'b0, 1'b0, STS_DONE},
        '{OP_QUERY, 32'hC0A9_0205, 6'd0,  1'b0, 1'b0, 1'b0, STS_DONE},
        '{OP_ADD,   32'h8000_0000, 6'd32, 1'b1, 1'b0, 1'b0, STS_DONE},
        '{OP_QUERY, 32'h0000_0001, 6'd0,  1'b0, 1'b0, 1'b0, STS_DONE},
        '{OP_ADD,   32'h0000_0001, 6'd32, 1'b0, 1'b0, 1'b0, STS_DONE},
        '{OP_QUERY, 32'h0000_0001, 6'd0,  1'b0, 1'b0, 1'b0, STS_DONE}
    };

    // A rule on the root matches everything, so it is only added once the rest is done.
    localparam t_request CLOSING [5] = '{
        '{OP_ADD,   32'h0000_0000, 6'd0,  1'b0, 1'b1, 1'b0, STS_DONE},
        '{OP_ADD,   32'h5A5A_5A5A, 6'd0,  1'b1, 1'b1, 1'b0, STS_SHADOW},
        '{OP_QUERY, 32'h5A5A_5A5A, 6'd0,  1'b0, 1'b0, 1'b0, STS_DONE},
        '{OP_ADD,   32'hA5A5_A5A5, 6'd17, 1'b1, 1'b1, 1'b0, STS_SHADOW},
        '{OP_QUERY, 32'h0A0A_0A0A, 6'd0,  1'b0, 1'b0, 1'b0, STS_DONE}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    iprt_in_if  req_if ();
    iprt_out_if rsp_if ();

    ipv4_prefix_rule_trie #(
        .NODE_COUNT(TRIE_NODES)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mirror of the node table.
    int unsigned trie_kid [TRIE_NODES][2];
    logic        trie_rule [TRIE_NODES];
    logic        trie_permit [TRIE_NODES];
    int unsigned trie_next_free;

    t_verdict    verdicts_due [$];
    t_request    cur_req;
    logic [31:0] addr_pool [32];
    int          reqs_taken = 0;
    int          errors = 0;
    int          cycle_count = 0;

    // Neither side idles while this window of transactions goes through.
    wire steady = (reqs_taken >= 600) && (reqs_taken < 900);

    // Applies one request to the mirrored trie and returns the response it should get.
    function automatic t_verdict trie_verdict(input t_request rq);
        t_verdict    res;
        int          depth;
        int          i;
        int unsigned pos;
        int unsigned nxt;
        logic        stop;
        res  = '{allowed: 1'b0, status: STS_DONE};
        pos  = 0;
        stop = 1'b0;
        if (rq.op == OP_ADD) begin
            depth = (rq.plen > MAX_DEPTH) ? int'(MAX_DEPTH) : int'(rq.plen);
            for (i = 0; i < depth && !stop; i++) begin
                if (trie_rule[pos]) begin
                    res.status = STS_SHADOW;
                    stop = 1'b1;
                end else begin
                    nxt = trie_kid[pos][rq.addr[31-i]];
                    if (nxt == 0) begin
                        if (trie_next_free >= TRIE_NODES) begin
                            res.status = STS_FULL;
                            stop = 1'b1;
                        end else begin
                            nxt = trie_next_free;
                            trie_next_free++;
                            trie_kid[nxt][0] = 0;
                            trie_kid[nxt][1] = 0;
                            trie_rule[nxt] = 1'b0;
                            trie_permit[nxt] = 1'b0;
                            trie_kid[pos][rq.addr[31-i]] = nxt;
                        end
                    end
                    if (!stop) pos = nxt;
                end
            end
            if (!stop) begin
                if (trie_rule[pos]) begin
                    res.status = STS_SHADOW;
                end else begin
                    trie_rule[pos] = 1'b1;
                    trie_permit[pos] = rq.permit;
                end
            end
        end else begin
            // The deepest rule on the path wins, the node at depth 32 included.
            res.allowed = 1'b1;
            for (i = 0; i <= 32 && !stop; i++) begin
                if (trie_rule[pos]) res.allowed = trie_permit[pos];
                if (i == 32) begin
                    stop = 1'b1;
                end else begin
                    nxt = trie_kid[pos][rq.addr[31-i]];
                    if (nxt == 0) stop = 1'b1;
                    else pos = nxt;
                end
            end
        end
        return res;
    endfunction

    // Presents one request from a falling edge and returns at the falling edge after acceptance.
    task automatic offer(input t_request rq);
        while (!steady && $urandom_range(99) < 20) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cur_req              <= rq;
        req_if.valid         <= 1'b1;
        req_if.opcode        <= rq.op;
        req_if.address       <= rq.addr;
        req_if.prefix_length <= rq.plen;
        req_if.permit        <= rq.permit;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        rsp_if.ready <= steady || ($urandom_range(99) >= 20);
    end

    always @(posedge i_clk) begin : check_responses
        t_verdict got;
        t_verdict want;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = '{allowed: rsp_if.allowed, status: rsp_if.status};
                if (verdicts_due.size() == 0) begin
                    errors++;
                    $display("%0t: response with nothing outstanding, allowed %0d status %0d",
                             $time, got.allowed, got.status);
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.allowed !== want.allowed) begin
                        errors++;
                        $display("%0t: allowed expected %0d, got %0d",
                                 $time, want.allowed, got.allowed);
                    end
                    if (got.status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, got.status);
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                // The mirror is updated even where the expectation is typed into the table.
                want = trie_verdict(cur_req);
                if (cur_req.fixed) want = '{allowed: cur_req.allowed, status: cur_req.status};
                verdicts_due.push_back(want);
                reqs_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_request    rq;
        int          n;
        int          k;
        int          sel;
        logic [31:0] mask;
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.opcode        = OP_ADD;
        req_if.address       = '0;
        req_if.prefix_length = '0;
        req_if.permit        = 1'b0;
        rsp_if.ready         = 1'b0;
        cur_req              = '0;
        for (n = 0; n < TRIE_NODES; n++) begin
            trie_kid[n][0] = 0;
            trie_kid[n][1] = 0;
            trie_rule[n]   = 1'b0;
            trie_permit[n] = 1'b0;
        end
        trie_next_free = 1;
        foreach (addr_pool[p]) addr_pool[p] = $urandom();

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (OPENING[r]) offer(OPENING[r]);

        // Addresses cluster around a pool of bases so that rules and queries share paths.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            k    = $urandom_range(32);
            mask = (k == 0) ? 32'h0 : (32'hFFFF_FFFF >> (32 - k));
            rq   = '0;
            rq.op = ($urandom_range(99) < 45) ? OP_ADD : OP_QUERY;
            if ($urandom_range(99) < 90) rq.addr = addr_pool[$urandom_range(31)] ^ ($urandom() & mask);
            else rq.addr = $urandom();
            sel = $urandom_range(99);
            if (rq.op == OP_QUERY) rq.plen = PLEN_W'($urandom_range(63));
            else if (sel < 4) rq.plen = PLEN_W'($urandom_range(1, 7));
            else if (sel < 14) rq.plen = PLEN_W'($urandom_range(33, 63));
            else rq.plen = PLEN_W'($urandom_range(12, 32));
            rq.permit = 1'($urandom_range(1));
            offer(rq);
        end

        // Make sure the table is exhausted, then knock on it a few more times.
        for (n = 0; n < 1000 && trie_next_free < TRIE_NODES; n++) begin
            rq = '{OP_ADD, $urandom(), 6'd32, 1'($urandom_range(1)), 1'b0, 1'b0, STS_DONE};
            offer(rq);
        end
        for (n = 0; n < 12; n++) begin
            rq      = '0;
            rq.op   = (n % 3 == 2) ? OP_QUERY : OP_ADD;
            rq.addr = $urandom();
            rq.plen = PLEN_W'($urandom_range(1, 63));
            offer(rq);
        end

        foreach (CLOSING[r]) offer(CLOSING[r]);
        req_if.valid <= 1'b0;

        while (verdicts_due.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
